/* src/ptq_pkg.sv */
// Shared types and codes for the periodic timer queue.
`default_nettype none
package ptq_pkg;

	localparam int TIME_W = 32;
	localparam int ID_W   = 4;
	localparam int NID_W  = 5;

	typedef enum logic [1:0] {
		ACT_ADD     = 2'd0,
		ACT_CLEAR   = 2'd1,
		ACT_ADVANCE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_SHIFT  = 2'd2
	} cell_op_t;

	typedef struct packed {
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] remaining;
		logic [ID_W-1:0]   id;
	} entry_t;

	// Broadcast from the controller to every cell in the row.
	typedef struct packed {
		cell_op_t          op;
		logic [TIME_W-1:0] key_period;
		logic [ID_W-1:0]   new_id;
		logic [TIME_W-1:0] head_rem;
	} cell_ctrl_t;

endpackage
`default_nettype wire

/* src/ptq_cell.sv */
// One queue cell: holds an entry and trades it with its neighbors.
`default_nettype none
module ptq_cell (
	input  wire logic               clk,
	input  wire ptq_pkg::cell_ctrl_t ctrl,
	input  wire logic               occ,
	input  wire logic               ins_left,
	input  wire ptq_pkg::entry_t    left,
	input  wire ptq_pkg::entry_t    right,
	output logic                    ins,
	output ptq_pkg::entry_t         entry
);

	ptq_pkg::entry_t entry_q;

	// The new entry belongs here or earlier when this cell is free or holds a later time.
	assign ins   = !occ || (entry_q.remaining > ctrl.key_period);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			ptq_pkg::CELL_HOLD: begin
				entry_q <= entry_q;
			end
			ptq_pkg::CELL_INSERT: begin
				if (ins_left) begin
					entry_q <= left;
				end else if (ins) begin
					entry_q.period    <= ctrl.key_period;
					entry_q.remaining <= ctrl.key_period;
					entry_q.id        <= ctrl.new_id;
				end
			end
			ptq_pkg::CELL_SHIFT: begin
				entry_q.period    <= right.period;
				entry_q.remaining <= right.remaining - ctrl.head_rem;
				entry_q.id        <= right.id;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule
`default_nettype wire

/* src/periodic_timer_queue_top.sv */
// Top level of the periodic timer queue: controller and a row of entry cells.
// A result is registered at the transfer of its action and shows in the cycle after it.
// Add, clear and unused codes finish at their transfer; an advance also holds in_ready
// low in ST_REINS: the row shifts left with the head time subtracted, then reinserts the head.
// Reset clears the fill count, the id counter, the sequencer and the output valid;
// the cell contents are not reset, because only occupied cells are ever read.
`default_nettype none
module periodic_timer_queue_top #(
	parameter int DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] period,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [3:0]       slot_id,
	output logic [31:0]      delay,
	output logic [4:0]       entry_count
);

	localparam int CW = $clog2(DEPTH + 1);

	// The sequencer is idle, or busy with the reinsertion half of an advance.
	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_REINS = 2'b10
	} state_t;

	state_t                    state_q, state_d;
	logic [CW-1:0]             count_q, count_d;
	logic [ptq_pkg::NID_W-1:0] next_id_q, next_id_d;
	ptq_pkg::entry_t           hold_q;
	logic                      out_valid_q;
	logic [1:0]                status_q, status_d;
	logic [3:0]                slot_id_q, slot_id_d;
	logic [31:0]               delay_q, delay_d;
	logic [4:0]                entry_count_q, entry_count_d;
	logic                      fire;
	logic                      save_head;
	ptq_pkg::cell_ctrl_t       ctrl;

	ptq_pkg::entry_t           cell_entry [DEPTH];
	logic                      cell_ins   [DEPTH];

	// A new action is taken only when the sequencer is idle and the result slot frees up.
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign fire     = in_valid && in_ready;

	// The row of cells. Each cell sees its left neighbor for sorted insertion and its
	// right neighbor for the shift that drops the head.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		ptq_pkg::entry_t left_e, right_e;
		logic            ins_l;
		logic            occ;

		assign occ = count_q > CW'(i);
		if (i == 0) begin : g_first
			assign left_e = cell_entry[i];
			assign ins_l  = 1'b0;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign ins_l  = cell_ins[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_e = cell_entry[i];
		end else begin : g_body
			assign right_e = cell_entry[i+1];
		end

		ptq_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occ      (occ),
			.ins_left (ins_l),
			.left     (left_e),
			.right    (right_e),
			.ins      (cell_ins[i]),
			.entry    (cell_entry[i])
		);
	end

	// Decode the action, steer the row and form the result.
	always_comb begin
		state_d         = state_q;
		count_d         = count_q;
		next_id_d       = next_id_q;
		save_head       = 1'b0;
		ctrl.op         = ptq_pkg::CELL_HOLD;
		ctrl.key_period = period;
		ctrl.new_id     = next_id_q[ptq_pkg::ID_W-1:0];
		ctrl.head_rem   = cell_entry[0].remaining;
		status_d        = ptq_pkg::STAT_OK;
		slot_id_d       = '0;
		delay_d         = '0;
		entry_count_d   = 5'(count_q);

		unique case (state_q)
			ST_IDLE: begin
				if (fire) begin
					unique case (action)
						ptq_pkg::ACT_ADD: begin
							if (count_q == CW'(DEPTH)) begin
								status_d = ptq_pkg::STAT_FULL;
							end else begin
								ctrl.op       = ptq_pkg::CELL_INSERT;
								count_d       = count_q + 1'b1;
								next_id_d     = next_id_q + 1'b1;
								slot_id_d     = next_id_q[ptq_pkg::ID_W-1:0];
								entry_count_d = 5'(count_d);
							end
						end
						ptq_pkg::ACT_CLEAR: begin
							count_d       = '0;
							next_id_d     = '0;
							entry_count_d = '0;
						end
						ptq_pkg::ACT_ADVANCE: begin
							if (count_q == '0) begin
								status_d = ptq_pkg::STAT_EMPTY;
							end else begin
								// The count drops here and comes back with the
								// reinsertion, so the reported count is unchanged.
								ctrl.op   = ptq_pkg::CELL_SHIFT;
								count_d   = count_q - 1'b1;
								save_head = 1'b1;
								slot_id_d = cell_entry[0].id;
								delay_d   = cell_entry[0].remaining;
								state_d   = ST_REINS;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_REINS: begin
				ctrl.op         = ptq_pkg::CELL_INSERT;
				ctrl.key_period = hold_q.period;
				ctrl.new_id     = hold_q.id;
				count_d         = count_q + 1'b1;
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			next_id_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			next_id_q <= next_id_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result and saved head carry no reset.
	always_ff @(posedge clk) begin
		if (save_head) begin
			hold_q <= cell_entry[0];
		end
		if (fire) begin
			status_q      <= status_d;
			slot_id_q     <= slot_id_d;
			delay_q       <= delay_d;
			entry_count_q <= entry_count_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot_id     = slot_id_q;
	assign delay       = delay_q;
	assign entry_count = entry_count_q;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the periodic timer queue with a built-in scheduler model.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int RANDOM_ITEMS = 1600;
	// Longest quiet stretch of a correct run is roughly a drawn sender gap, the work for
	// an advance and a drawn receiver stall; allow far more.
	localparam int IDLE_LIMIT = 400;
	// The result shows in the cycle after its transfer, so DRAIN_CYCLES suffices to catch
	// any stray output once everything expected has arrived.
	localparam int DRAIN_CYCLES = 10;
	// Action code 3 is not decoded by the block and must leave the queue alone.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  act;
		logic [31:0] per;
	} timer_cmd_t;

	typedef struct {
		ptq_pkg::status_t status;
		logic [3:0]       slot;
		logic [31:0]      delay;
		logic [4:0]       count;
	} timer_result_t;

	// Clock, reset and the block's ports. Every input starts at a known value.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = 2'd0;
	logic [31:0] period = 32'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [3:0]  slot_id;
	logic [31:0] delay;
	logic [4:0]  entry_count;

	// Stimulus waiting to be driven and results waiting to be seen.
	timer_cmd_t    pending_cmds[$];
	timer_result_t due_results[$];
	int            total_cmds = 0;
	int            useful_cmds = 0;

	// Transfer counters; each is written only by the rising-edge monitor, so the
	// falling-edge drivers can tell that their item or result has been taken.
	int in_xfers = 0;
	int out_xfers = 0;
	int errors = 0;

	// Scheduler model: entries sorted by remaining ticks, ties in arrival order.
	logic [31:0] sched_period[DEPTH];
	logic [31:0] sched_rem[DEPTH];
	logic [3:0]  sched_id[DEPTH];
	int          sched_fill = 0;
	logic [4:0]  id_counter = 5'd0;

	// What the run went through, for the closing summary.
	int n_added = 0;
	int n_full = 0;
	int n_fired = 0;
	int n_empty = 0;
	int n_clear = 0;
	int n_unused = 0;
	int peak_fill = 0;

	periodic_timer_queue_top #(
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.period(period),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.slot_id(slot_id),
		.delay(delay),
		.entry_count(entry_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Put an entry behind every entry whose remaining is equal or smaller. The caller
	// makes sure there is room.
	task automatic insert_sorted(input logic [31:0] per, input logic [31:0] rem,
			input logic [3:0] id);
		int pos;
		int k;
		pos = 0;
		while (pos < sched_fill && sched_rem[pos] <= rem)
			pos++;
		for (k = sched_fill; k > pos; k--) begin
			sched_period[k] = sched_period[k-1];
			sched_rem[k]    = sched_rem[k-1];
			sched_id[k]     = sched_id[k-1];
		end
		sched_period[pos] = per;
		sched_rem[pos]    = rem;
		sched_id[pos]     = id;
		sched_fill++;
	endtask

	// Apply one accepted action to the scheduler model and work out the result the
	// block has to return for it.
	task automatic schedule_action(input logic [1:0] act, input logic [31:0] per,
			output timer_result_t res);
		logic [31:0] head_per;
		logic [31:0] head_rem;
		logic [3:0]  head_id;
		int          k;
		res.status = ptq_pkg::STAT_OK;
		res.slot   = 4'd0;
		res.delay  = 32'd0;
		case (act)
			ptq_pkg::ACT_ADD: begin
				if (sched_fill >= DEPTH) begin
					// A full queue rejects the add and keeps its id counter.
					res.status = ptq_pkg::STAT_FULL;
					n_full++;
				end else begin
					insert_sorted(per, per, id_counter[3:0]);
					res.slot   = id_counter[3:0];
					id_counter = id_counter + 5'd1;
					n_added++;
				end
			end
			ptq_pkg::ACT_CLEAR: begin
				sched_fill = 0;
				id_counter = 5'd0;
				n_clear++;
			end
			ptq_pkg::ACT_ADVANCE: begin
				if (sched_fill == 0) begin
					res.status = ptq_pkg::STAT_EMPTY;
					n_empty++;
				end else begin
					// The head leaves, the rest move up and lose its remaining time,
					// then the head comes back with a fresh period.
					head_per = sched_period[0];
					head_rem = sched_rem[0];
					head_id  = sched_id[0];
					for (k = 1; k < sched_fill; k++) begin
						sched_period[k-1] = sched_period[k];
						sched_rem[k-1]    = sched_rem[k] - head_rem;
						sched_id[k-1]     = sched_id[k];
					end
					sched_fill--;
					insert_sorted(head_per, head_per, head_id);
					res.slot  = head_id;
					res.delay = head_rem;
					n_fired++;
				end
			end
			default: begin
				n_unused++;
			end
		endcase
		res.count = 5'(sched_fill);
		if (sched_fill > peak_fill)
			peak_fill = sched_fill;
	endtask

	// Compare one field of a result and report a difference.
	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name,
				want, got);
			errors++;
		end
	endfunction

	// Periods lean towards small values so that ties and equal remaining times are
	// common, with full-range, zero and all-ones values mixed in.
	function automatic logic [31:0] draw_period();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return $urandom_range(1, 12);
		else if (pick < 75)
			return $urandom_range(13, 1000);
		else if (pick < 90)
			return $urandom;
		else if (pick < 95)
			return 32'd0;
		else
			return 32'hFFFF_FFFF;
	endfunction

	// Cycles to idle before the next transfer; a calm stretch does not idle at all.
	function automatic int draw_wait(input bit calm);
		if (calm)
			return 0;
		return $urandom_range(0, 8);
	endfunction

	task automatic push_cmd(input logic [1:0] act, input logic [31:0] per);
		timer_cmd_t cmd;
		cmd.act = act;
		cmd.per = per;
		pending_cmds.push_back(cmd);
		total_cmds++;
		if (act != ACT_UNUSED)
			useful_cmds++;
	endtask

	// Rising-edge monitor: every input transfer feeds the scheduler model, and every
	// output transfer is checked against the oldest result still due.
	always @(posedge clk) begin
		timer_cmd_t    cmd;
		timer_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				cmd.act = action;
				cmd.per = period;
				schedule_action(cmd.act, cmd.per, want);
				due_results.push_back(want);
				in_xfers++;
			end
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with none due, status %0d slot %0d",
						$time, status, slot_id);
					$display("%0t: delay 0x%08h count %0d", $time, delay,
						entry_count);
					errors++;
				end else begin
					want = due_results[0];
					due_results.delete(0);
					check_field("status", 32'(want.status), 32'(status));
					check_field("slot_id", 32'(want.slot), 32'(slot_id));
					check_field("delay", want.delay, delay);
					check_field("entry_count", 32'(want.count), 32'(entry_count));
				end
				out_xfers++;
			end
		end
	end

	// Falling-edge driver for the action channel. Valid stays high with the payload
	// unchanged until the transfer; then a gap is drawn and, if the gap is zero, the
	// next item follows at once without valid dropping.
	int in_seen = 0;
	int in_wait = 0;
	bit in_calm = 1'b0;

	always @(negedge clk) begin
		timer_cmd_t cmd;
		if (arst_n && !(in_valid && in_xfers == in_seen)) begin
			if (in_xfers != in_seen) begin
				in_seen = in_xfers;
				if ($urandom_range(0, 49) == 0)
					in_calm = !in_calm;
				in_wait = draw_wait(in_calm);
			end
			if (in_wait == 0 && pending_cmds.size() != 0) begin
				cmd = pending_cmds[0];
				pending_cmds.delete(0);
				in_valid <= 1'b1;
				action   <= cmd.act;
				period   <= cmd.per;
			end else begin
				in_valid <= 1'b0;
				if (in_wait > 0)
					in_wait--;
			end
		end
	end

	// Falling-edge driver for the result channel: after each transfer ready drops for
	// a drawn number of cycles, so stalls land on every phase of an advance.
	int out_seen = 0;
	int out_wait = 0;
	bit out_calm = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_xfers != out_seen) begin
				out_seen = out_xfers;
				if ($urandom_range(0, 49) == 0)
					out_calm = !out_calm;
				out_wait = draw_wait(out_calm);
			end
			if (out_wait > 0) begin
				out_ready <= 1'b0;
				out_wait--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: a correct block never goes this long without a transfer on either side.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("periodic_timer_queue_top test failed");
			$finish;
		end
	end

	initial begin
		int n_adds;
		int n_steps;
		int pick;
		int directed_useful;

		// Directed part. An advance on the empty queue and an unused code come first.
		push_cmd(ptq_pkg::ACT_ADVANCE, 32'h1234_5678);
		push_cmd(ACT_UNUSED, 32'hFFFF_FFFF);
		// Fill the queue: zero and all-ones periods, the extremes, and several ties.
		push_cmd(ptq_pkg::ACT_ADD, 32'd0);
		push_cmd(ptq_pkg::ACT_ADD, 32'hFFFF_FFFF);
		push_cmd(ptq_pkg::ACT_ADD, 32'd1);
		push_cmd(ptq_pkg::ACT_ADD, 32'd7);
		push_cmd(ptq_pkg::ACT_ADD, 32'd7);
		push_cmd(ptq_pkg::ACT_ADD, 32'd3);
		push_cmd(ptq_pkg::ACT_ADD, 32'd7);
		push_cmd(ptq_pkg::ACT_ADD, 32'd1);
		push_cmd(ptq_pkg::ACT_ADD, 32'h8000_0000);
		push_cmd(ptq_pkg::ACT_ADD, 32'd2);
		push_cmd(ptq_pkg::ACT_ADD, 32'd5);
		push_cmd(ptq_pkg::ACT_ADD, 32'd5);
		push_cmd(ptq_pkg::ACT_ADD, 32'd12);
		push_cmd(ptq_pkg::ACT_ADD, 32'd9);
		push_cmd(ptq_pkg::ACT_ADD, 32'd4);
		push_cmd(ptq_pkg::ACT_ADD, 32'd7);
		// The queue is full now, so this add is rejected.
		push_cmd(ptq_pkg::ACT_ADD, 32'd6);
		// The zero-period entry keeps firing with no delay.
		push_cmd(ptq_pkg::ACT_ADVANCE, 32'd0);
		push_cmd(ptq_pkg::ACT_ADVANCE, 32'hFFFF_FFFF);
		push_cmd(ptq_pkg::ACT_ADVANCE, 32'd0);
		push_cmd(ACT_UNUSED, 32'd0);
		push_cmd(ptq_pkg::ACT_CLEAR, 32'hFFFF_FFFF);
		push_cmd(ptq_pkg::ACT_ADVANCE, 32'd0);
		directed_useful = useful_cmds;

		// Random part: episodes that mostly start from an empty queue, load a batch of
		// entries (sometimes past full) and then run a mix dominated by advances.
		while (useful_cmds - directed_useful < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0)
				push_cmd(ptq_pkg::ACT_CLEAR, $urandom);
			n_adds = $urandom_range(1, 18);
			repeat (n_adds)
				push_cmd(ptq_pkg::ACT_ADD, draw_period());
			n_steps = $urandom_range(10, 50);
			repeat (n_steps) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					push_cmd(ptq_pkg::ACT_ADVANCE, $urandom);
				else if (pick < 93)
					push_cmd(ptq_pkg::ACT_ADD, draw_period());
				else if (pick < 97)
					push_cmd(ACT_UNUSED, $urandom);
				else
					push_cmd(ptq_pkg::ACT_CLEAR, $urandom);
			end
		end

		// Reset is held low from the start and released on a falling edge; the drivers
		// see it released from the next falling edge on.
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait until every item has been taken and every result has come back.
		do
			@(negedge clk);
		while (in_xfers != total_cmds || due_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d actions: %0d adds, %0d rejected on a full queue,",
			total_cmds, n_added, n_full);
		$display("%0d clears, %0d unused codes; %0d advances fired an entry,",
			n_clear, n_unused, n_fired);
		$display("%0d advances hit an empty queue; peak fill %0d of %0d.",
			n_empty, peak_fill, DEPTH);
		if (errors == 0) begin
			$display("periodic_timer_queue_top test passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("periodic_timer_queue_top test failed");
		end
		$finish;
	end

endmodule
